// ===== rtl/qpht_pkg.sv =====
// ----------------------------------------------------------------------------
// qpht_pkg: shared types and constants of the quadratic probe hash table
// Field widths, operation, status and slot mark codes, register indexes and
// the request and response payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package qpht_pkg;

	localparam int MAX_SLOTS_DEF = 1024;

	localparam int MODE_W      = 2;
	localparam int KEY_W       = 31;
	localparam int STATUS_W    = 3;
	localparam int SLOT_W      = 10;
	localparam int MARK_W      = 2;
	localparam int SLOTS_CFG_W = 11;
	localparam int LOAD_CFG_W  = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = SLOTS_CFG_W;

	localparam int SLOTS_RESET  = 1021;
	localparam int SLOTS_MIN    = 2;
	localparam int LOAD_RESET   = 80;
	localparam int LOAD_MIN     = 1;
	localparam int LOAD_MAX     = 100;
	localparam int PERCENT_FULL = 100;

	// key mod size: restoring remainder, DIGIT_W bits per cycle
	localparam int DIGIT_W    = 4;
	localparam int KEY_PAD_W  = 32;
	localparam int HASH_STEPS = KEY_PAD_W / DIGIT_W;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PROBE_LIMIT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LOAD_LIMIT  = 3'd4;

	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT = 2'd1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/qpht_slot_mem.sv =====
// ----------------------------------------------------------------------------
// qpht_slot_mem: slot mark and key storage
// Two synchronous arrays sharing one write and one read address, read data
// registered. Key entries are written only on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module qpht_slot_mem #(
	parameter int DEPTH = qpht_pkg::MAX_SLOTS_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          rd_en,
	input  wire logic [IDX_W-1:0]              rd_addr,
	output logic      [qpht_pkg::MARK_W-1:0]   rd_mark,
	output logic      [qpht_pkg::KEY_W-1:0]    rd_key,
	input  wire logic                          wr_en,
	input  wire logic                          wr_key_en,
	input  wire logic [IDX_W-1:0]              wr_addr,
	input  wire logic [qpht_pkg::MARK_W-1:0]   wr_mark,
	input  wire logic [qpht_pkg::KEY_W-1:0]    wr_key
);

	logic [qpht_pkg::MARK_W-1:0] mark_mem [DEPTH];
	logic [qpht_pkg::KEY_W-1:0]  key_mem  [DEPTH];
	logic [qpht_pkg::MARK_W-1:0] mark_q;
	logic [qpht_pkg::KEY_W-1:0]  key_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mark_mem[wr_addr] <= wr_mark;
		end
		if (wr_key_en) begin
			key_mem[wr_addr] <= wr_key;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mark_q <= mark_mem[rd_addr];
			key_q  <= key_mem[rd_addr];
		end
	end

	assign rd_mark = mark_q;
	assign rd_key  = key_q;

endmodule

`default_nettype wire

// ===== rtl/qpht_mod_unit.sv =====
// ----------------------------------------------------------------------------
// qpht_mod_unit: home slot computation
// Key mod table size by restoring remainder, four key bits per cycle.
// done pulses for one cycle with home valid.
// ----------------------------------------------------------------------------
`default_nettype none

module qpht_mod_unit #(
	parameter int SIZE_W = 11,
	parameter int IDX_W  = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [qpht_pkg::KEY_W-1:0] key,
	input  wire logic [SIZE_W-1:0]          size,
	output logic                            done,
	output logic      [IDX_W-1:0]           home
);

	localparam int RW     = SIZE_W + 1;
	localparam int PAD_W  = qpht_pkg::KEY_PAD_W;
	localparam int DIG_W  = qpht_pkg::DIGIT_W;
	localparam int STEPS  = qpht_pkg::HASH_STEPS;
	localparam int STEP_W = $clog2(STEPS);

	logic [PAD_W-1:0]  sh_q;
	logic [RW-1:0]     rem_q;
	logic [RW-1:0]     rem_n;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;

	always_comb begin
		rem_n = rem_q;
		for (int j = 0; j < DIG_W; j++) begin
			rem_n = {rem_n[RW-2:0], sh_q[PAD_W-1-j]};
			if (rem_n >= RW'(size)) begin
				rem_n = rem_n - RW'(size);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= PAD_W'(key);
			rem_q <= '0;
		end else if (run_q) begin
			sh_q  <= sh_q << DIG_W;
			rem_q <= rem_n;
		end
	end

	assign done = done_q;
	assign home = IDX_W'(rem_q);

endmodule

`default_nettype wire

// ===== rtl/qpht_probe_gen.sv =====
// ----------------------------------------------------------------------------
// qpht_probe_gen: quadratic probe address generator
// Steps (home + i*i) mod size incrementally: the address grows by 2i+1 and
// the step by 2, each kept below size by one compare and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module qpht_probe_gen #(
	parameter int SIZE_W = 11,
	parameter int IDX_W  = 10
) (
	input  wire logic              clk,
	input  wire logic              load,
	input  wire logic              advance,
	input  wire logic [IDX_W-1:0]  home,
	input  wire logic [SIZE_W-1:0] size,
	output logic      [IDX_W-1:0]  addr
);

	localparam int PW = IDX_W + 1;

	logic [IDX_W-1:0] p_q;
	logic [IDX_W-1:0] d_q;
	logic [PW-1:0]    p_sum;
	logic [PW-1:0]    d_sum;

	always_comb begin
		p_sum = PW'(p_q) + PW'(d_q);
		if (p_sum >= PW'(size)) begin
			p_sum = p_sum - PW'(size);
		end
		d_sum = PW'(d_q) + PW'(2);
		if (d_sum >= PW'(size)) begin
			d_sum = d_sum - PW'(size);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			p_q <= home;
			d_q <= IDX_W'(1);
		end else if (advance) begin
			p_q <= IDX_W'(p_sum);
			d_q <= IDX_W'(d_sum);
		end
	end

	assign addr = p_q;

endmodule

`default_nettype wire

// ===== rtl/quadratic_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table: open-addressing hash set, quadratic probing
// After reset the block holds busy high while it marks every slot empty. A
// request is taken when start is high and busy low; one request is worked
// at a time. For insert, search and remove, key mod size is computed four
// bits per cycle, then the slot memory is read once per probe with
// registered read data, and a decide step decides and writes back. An
// unused mode answers in the next cycle. The result is shown for one
// cycle with done high and cannot be held off; capture it.
// Configuration writes are taken at any time, ready is always high, and
// must be done only while no request is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_probe_hash_table #(
	parameter int MAX_SLOTS = qpht_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire qpht_pkg::req_t                  req,
	output logic                                 done,
	output qpht_pkg::rsp_t                       rsp,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [qpht_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [qpht_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W      = $clog2(MAX_SLOTS);
	localparam int SIZE_W     = $clog2(MAX_SLOTS + 1);
	localparam int LOAD_W     = qpht_pkg::LOAD_CFG_W;
	localparam int PROD_W     = SIZE_W + LOAD_W;
	localparam int SLOT_W     = qpht_pkg::SLOT_W;
	localparam int SIZE_RESET = (qpht_pkg::SLOTS_RESET > MAX_SLOTS) ?
		MAX_SLOTS : qpht_pkg::SLOTS_RESET;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_FIND,
		S_DECIDE
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0] size_q;
	logic [LOAD_W-1:0] lim_q;
	logic [SIZE_W-1:0] size_sat;
	logic [LOAD_W-1:0] lim_sat;
	logic [LOAD_W-1:0] lim_raw;

	logic [PROD_W-1:0] cnt_x100_q;
	logic [PROD_W-1:0] lim_size_q;
	logic [SIZE_W-1:0] cnt_q;
	logic              load_over;

	logic [qpht_pkg::MODE_W-1:0] mode_q;
	logic [qpht_pkg::KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]            clr_idx_q;
	logic [SIZE_W-1:0]           probe_n_q;
	logic [IDX_W-1:0]            addr_s1;
	logic                        vld_s1;
	logic                        found_q;
	logic [IDX_W-1:0]            found_slot_q;
	logic                        free_found_q;
	logic [IDX_W-1:0]            free_slot_q;
	logic                        done_q;
	qpht_pkg::rsp_t              rsp_q;

	logic                        mode_ok;
	logic                        hash_start;
	logic                        hash_done;
	logic [IDX_W-1:0]            home;
	logic [IDX_W-1:0]            probe_addr;
	logic [qpht_pkg::MARK_W-1:0] rd_mark;
	logic [qpht_pkg::KEY_W-1:0]  rd_key;
	logic                        stop_hit;
	logic                        stop_empty;
	logic                        exhausted;
	logic                        find_stop;
	logic                        issue;

	logic                        mem_wr_en;
	logic                        mem_wr_key_en;
	logic [IDX_W-1:0]            mem_wr_addr;
	logic [qpht_pkg::MARK_W-1:0] mem_wr_mark;

	// configuration
	assign lim_raw = cfg_data[LOAD_W-1:0];

	always_comb begin
		if (32'(cfg_data) < qpht_pkg::SLOTS_MIN) begin
			size_sat = SIZE_W'(qpht_pkg::SLOTS_MIN);
		end else if (32'(cfg_data) > MAX_SLOTS) begin
			size_sat = SIZE_W'(MAX_SLOTS);
		end else begin
			size_sat = SIZE_W'(cfg_data);
		end
		if (32'(lim_raw) < qpht_pkg::LOAD_MIN) begin
			lim_sat = LOAD_W'(qpht_pkg::LOAD_MIN);
		end else if (32'(lim_raw) > qpht_pkg::LOAD_MAX) begin
			lim_sat = LOAD_W'(qpht_pkg::LOAD_MAX);
		end else begin
			lim_sat = lim_raw;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(SIZE_RESET);
			lim_q  <= LOAD_W'(qpht_pkg::LOAD_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				qpht_pkg::CFG_SLOTS:      size_q <= size_sat;
				qpht_pkg::CFG_LOAD_LIMIT: lim_q  <= lim_sat;
				default: ;
			endcase
		end
	end

	// load limit products, refreshed every cycle
	always_ff @(posedge clk) begin
		cnt_x100_q <= PROD_W'(cnt_q) * PROD_W'(qpht_pkg::PERCENT_FULL);
		lim_size_q <= PROD_W'(lim_q) * PROD_W'(size_q);
	end

	assign load_over = cnt_x100_q > lim_size_q;

	// datapath units
	assign mode_ok = (req.mode == qpht_pkg::MODE_INSERT) ||
		(req.mode == qpht_pkg::MODE_SEARCH) || (req.mode == qpht_pkg::MODE_REMOVE);
	assign hash_start = (state_q == S_IDLE) && start && mode_ok;

	qpht_mod_unit #(
		.SIZE_W (SIZE_W),
		.IDX_W  (IDX_W)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (req.key),
		.size   (size_q),
		.done   (hash_done),
		.home   (home)
	);

	qpht_probe_gen #(
		.SIZE_W (SIZE_W),
		.IDX_W  (IDX_W)
	) u_probe (
		.clk     (clk),
		.load    (hash_done),
		.advance (issue),
		.home    (home),
		.size    (size_q),
		.addr    (probe_addr)
	);

	qpht_slot_mem #(
		.DEPTH (MAX_SLOTS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk       (clk),
		.rd_en     (issue),
		.rd_addr   (probe_addr),
		.rd_mark   (rd_mark),
		.rd_key    (rd_key),
		.wr_en     (mem_wr_en),
		.wr_key_en (mem_wr_key_en),
		.wr_addr   (mem_wr_addr),
		.wr_mark   (mem_wr_mark),
		.wr_key    (key_q)
	);

	// probe walk
	assign stop_hit   = vld_s1 && (rd_mark == qpht_pkg::MARK_USED) && (rd_key == key_q);
	assign stop_empty = vld_s1 && (rd_mark == qpht_pkg::MARK_EMPTY);
	assign exhausted  = !vld_s1 && (probe_n_q == size_q);
	assign find_stop  = stop_hit || stop_empty || exhausted;
	assign issue      = (state_q == S_FIND) && !find_stop && (probe_n_q != size_q);

	// write back
	always_comb begin
		mem_wr_en     = 1'b0;
		mem_wr_key_en = 1'b0;
		mem_wr_addr   = free_slot_q;
		mem_wr_mark   = qpht_pkg::MARK_USED;
		if (state_q == S_CLEAR) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = clr_idx_q;
			mem_wr_mark = qpht_pkg::MARK_EMPTY;
		end else if (state_q == S_DECIDE) begin
			if ((mode_q == qpht_pkg::MODE_INSERT) && !found_q && !load_over && free_found_q) begin
				mem_wr_en     = 1'b1;
				mem_wr_key_en = 1'b1;
			end else if ((mode_q == qpht_pkg::MODE_REMOVE) && found_q) begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = found_slot_q;
				mem_wr_mark = qpht_pkg::MARK_GONE;
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_idx_q    <= '0;
			cnt_q        <= '0;
			probe_n_q    <= '0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == IDX_W'(MAX_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						mode_q <= req.mode;
						key_q  <= req.key;
						if (mode_ok) begin
							state_q <= S_HASH;
						end else begin
							done_q       <= 1'b1;
							rsp_q.status <= qpht_pkg::ST_NOT_FOUND;
							rsp_q.slot   <= '0;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q      <= S_FIND;
						probe_n_q    <= '0;
						vld_s1       <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
					end
				end
				S_FIND: begin
					vld_s1 <= issue;
					if (issue) begin
						addr_s1   <= probe_addr;
						probe_n_q <= probe_n_q + SIZE_W'(1);
					end
					// first empty or deleted slot on the walk is the insert target
					if (vld_s1 && (rd_mark != qpht_pkg::MARK_USED) && !free_found_q) begin
						free_found_q <= 1'b1;
						free_slot_q  <= addr_s1;
					end
					if (stop_hit) begin
						found_q      <= 1'b1;
						found_slot_q <= addr_s1;
					end
					if (find_stop) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q      <= S_IDLE;
					done_q       <= 1'b1;
					rsp_q.slot   <= '0;
					rsp_q.status <= qpht_pkg::ST_NOT_FOUND;
					unique case (mode_q)
						qpht_pkg::MODE_INSERT: begin
							if (found_q) begin
								rsp_q.status <= qpht_pkg::ST_DUPLICATE;
							end else if (load_over) begin
								rsp_q.status <= qpht_pkg::ST_LOAD_LIMIT;
							end else if (free_found_q) begin
								rsp_q.status <= qpht_pkg::ST_OK;
								rsp_q.slot   <= SLOT_W'(free_slot_q);
								cnt_q        <= cnt_q + SIZE_W'(1);
							end else begin
								rsp_q.status <= qpht_pkg::ST_PROBE_LIMIT;
							end
						end
						qpht_pkg::MODE_SEARCH: begin
							if (found_q) begin
								rsp_q.status <= qpht_pkg::ST_OK;
								rsp_q.slot   <= SLOT_W'(found_slot_q);
							end
						end
						qpht_pkg::MODE_REMOVE: begin
							if (found_q) begin
								rsp_q.status <= qpht_pkg::ST_OK;
								rsp_q.slot   <= SLOT_W'(found_slot_q);
								if (cnt_q != '0) begin
									cnt_q <= cnt_q - SIZE_W'(1);
								end
							end
						end
						default: ;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// checks
	a_find_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |-> !mem_wr_en)
		else $error("slot memory written during probe walk");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |-> (probe_n_q <= size_q))
		else $error("probe count beyond table size");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_SLOTS)
		else $error("occupied count beyond slot count");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != qpht_pkg::ST_OK)) |-> (rsp.slot == '0))
		else $error("nonzero slot on failed request");

	a_result_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(state_q != S_IDLE)) |-> $past(state_q == S_DECIDE))
		else $error("result outside decide step");

endmodule

`default_nettype wire

// ===== sim/quadratic_probe_hash_table_test.sv =====
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_test: self-checking bench for the hash table
// Drives insert, search, remove and unused-mode requests and rewrites the
// table size and the load limit between phases. A behavioral copy of the
// table predicts the status and slot of every request. Each result is
// compared with the oldest prediction. Directed cases cover key extremes,
// collisions, tombstones, register saturation and resizing a table that
// holds entries. Random phases then run with and without sender idle time.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = qpht_pkg::MAX_SLOTS_DEF;
	localparam int PHASE_ITEMS = 125;
	localparam int POOL_DEPTH = 40;
	localparam int DRAIN_CYCLES = 64;
	localparam int MAX_REPORTS = 40;
	localparam longint LIMIT_CYCLES = 8000000;

	localparam logic [qpht_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [qpht_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	qpht_pkg::req_t req;
	logic done;
	qpht_pkg::rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [qpht_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [qpht_pkg::CFG_DATA_W-1:0] cfg_data;

	// behavioral copy of the table
	logic [qpht_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
	logic [qpht_pkg::MARK_W-1:0] mark_mem [TABLE_DEPTH];
	int unsigned live_count;
	int unsigned model_slots;
	int unsigned load_pct;

	qpht_pkg::rsp_t pending_rsp [$];
	qpht_pkg::req_t pending_req [$];
	logic [qpht_pkg::KEY_W-1:0] key_pool [$];

	longint cycle_count = 0;
	int unsigned sent_count = 0;
	int unsigned checked_count = 0;
	int unsigned cfg_count = 0;
	int unsigned mismatch_count = 0;

	qpht_pkg::rsp_t want;
	qpht_pkg::req_t asked;

	quadratic_probe_hash_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int unsigned probe_slot(input int unsigned home, input int unsigned i);
		longint unsigned h;
		longint unsigned n;
		h = home;
		n = i;
		return 32'((h + n * n) % model_slots);
	endfunction

	function automatic bit locate_key(input logic [qpht_pkg::KEY_W-1:0] key,
			output int unsigned hit_slot);
		int unsigned home;
		int unsigned s;
		home = key % model_slots;
		hit_slot = 0;
		for (int unsigned i = 0; i < model_slots; i++) begin
			s = probe_slot(home, i);
			if (mark_mem[s] == qpht_pkg::MARK_EMPTY)
				return 1'b0;
			if (mark_mem[s] == qpht_pkg::MARK_USED && key_mem[s] == key) begin
				hit_slot = s;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic qpht_pkg::rsp_t hash_set_apply(input qpht_pkg::req_t r);
		qpht_pkg::rsp_t o;
		int unsigned s;
		int unsigned home;
		bit placed;
		o.status = qpht_pkg::ST_NOT_FOUND;
		o.slot = '0;
		placed = 1'b0;
		case (r.mode)
			qpht_pkg::MODE_INSERT: begin
				if (locate_key(r.key, s)) begin
					o.status = qpht_pkg::ST_DUPLICATE;
				end else if (live_count * qpht_pkg::PERCENT_FULL >
						load_pct * model_slots) begin
					o.status = qpht_pkg::ST_LOAD_LIMIT;
				end else begin
					o.status = qpht_pkg::ST_PROBE_LIMIT;
					home = r.key % model_slots;
					for (int unsigned i = 0; i < model_slots && !placed; i++) begin
						s = probe_slot(home, i);
						if (mark_mem[s] != qpht_pkg::MARK_USED) begin
							key_mem[s] = r.key;
							mark_mem[s] = qpht_pkg::MARK_USED;
							live_count++;
							o.status = qpht_pkg::ST_OK;
							o.slot = s[qpht_pkg::SLOT_W-1:0];
							placed = 1'b1;
						end
					end
				end
			end
			qpht_pkg::MODE_SEARCH: begin
				if (locate_key(r.key, s)) begin
					o.status = qpht_pkg::ST_OK;
					o.slot = s[qpht_pkg::SLOT_W-1:0];
				end
			end
			qpht_pkg::MODE_REMOVE: begin
				if (locate_key(r.key, s)) begin
					mark_mem[s] = qpht_pkg::MARK_GONE;
					if (live_count > 0)
						live_count--;
					o.status = qpht_pkg::ST_OK;
					o.slot = s[qpht_pkg::SLOT_W-1:0];
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic qpht_pkg::req_t make_req(input logic [qpht_pkg::MODE_W-1:0] mode,
			input logic [qpht_pkg::KEY_W-1:0] key);
		qpht_pkg::req_t r;
		r.mode = mode;
		r.key = key;
		return r;
	endfunction

	function automatic qpht_pkg::req_t next_random_request();
		qpht_pkg::req_t r;
		int unsigned pick;
		logic [31:0] raw;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.mode = qpht_pkg::MODE_INSERT;
		else if (pick < 75)
			r.mode = qpht_pkg::MODE_SEARCH;
		else if (pick < 95)
			r.mode = qpht_pkg::MODE_REMOVE;
		else
			r.mode = MODE_UNUSED;
		pick = $urandom_range(0, 99);
		if (key_pool.size() != 0 && pick < 60) begin
			r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
		end else begin
			if (pick < 80)
				raw = $urandom_range(0, 255);
			else
				raw = $urandom();
			r.key = raw[qpht_pkg::KEY_W-1:0];
			key_pool.push_back(r.key);
			if (key_pool.size() > POOL_DEPTH)
				void'(key_pool.pop_front());
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("MISMATCH cycle %0d: %s", cycle_count, what);
	endtask

	task automatic send_request(input qpht_pkg::req_t item);
		qpht_pkg::rsp_t expected;
		@(negedge clk);
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy);
		expected = hash_set_apply(item);
		pending_rsp.push_back(expected);
		pending_req.push_back(item);
		sent_count++;
	endtask

	task automatic hold_off(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_register(input logic [qpht_pkg::CFG_IDX_W-1:0] index,
			input int unsigned value);
		logic [qpht_pkg::CFG_DATA_W-1:0] data;
		logic [qpht_pkg::LOAD_CFG_W-1:0] pct;
		int unsigned v;
		data = value[qpht_pkg::CFG_DATA_W-1:0];
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			qpht_pkg::CFG_SLOTS: begin
				v = data;
				if (v < qpht_pkg::SLOTS_MIN)
					v = qpht_pkg::SLOTS_MIN;
				if (v > TABLE_DEPTH)
					v = TABLE_DEPTH;
				model_slots = v;
			end
			qpht_pkg::CFG_LOAD_LIMIT: begin
				pct = data[qpht_pkg::LOAD_CFG_W-1:0];
				v = pct;
				if (v < qpht_pkg::LOAD_MIN)
					v = qpht_pkg::LOAD_MIN;
				if (v > qpht_pkg::LOAD_MAX)
					v = qpht_pkg::LOAD_MAX;
				load_pct = v;
			end
			default: begin
			end
		endcase
		cfg_count++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_default_config();
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd0));
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'h7FFF_FFFF));
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd1021));
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd0));
		send_request(make_req(qpht_pkg::MODE_SEARCH, 31'd1021));
		send_request(make_req(qpht_pkg::MODE_SEARCH, 31'd5));
		send_request(make_req(qpht_pkg::MODE_REMOVE, 31'd0));
		send_request(make_req(qpht_pkg::MODE_SEARCH, 31'd1021));
		send_request(make_req(MODE_UNUSED, 31'h7FFF_FFFF));
	endtask

	task automatic test_register_limits();
		write_register(qpht_pkg::CFG_SLOTS, 0);
		write_register(qpht_pkg::CFG_LOAD_LIMIT, 127);
		write_register(CFG_UNUSED, 2047);
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd4));
		send_request(make_req(qpht_pkg::MODE_REMOVE, 31'd1021));
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd8));
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd6));
		write_register(qpht_pkg::CFG_LOAD_LIMIT, 128);
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd10));
		write_register(qpht_pkg::CFG_SLOTS, 2047);
		write_register(qpht_pkg::CFG_SLOTS, 1);
		write_register(qpht_pkg::CFG_LOAD_LIMIT, 0);
		send_request(make_req(qpht_pkg::MODE_SEARCH, 31'd8));
	endtask

	task automatic test_tombstone_chain();
		write_register(qpht_pkg::CFG_SLOTS, 7);
		write_register(qpht_pkg::CFG_LOAD_LIMIT, 100);
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd3));
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd10));
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd17));
		send_request(make_req(qpht_pkg::MODE_REMOVE, 31'd10));
		send_request(make_req(qpht_pkg::MODE_SEARCH, 31'd17));
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd17));
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd24));
	endtask

	task automatic test_resize_in_use();
		write_register(qpht_pkg::CFG_SLOTS, 5);
		send_request(make_req(qpht_pkg::MODE_SEARCH, 31'd17));
		send_request(make_req(qpht_pkg::MODE_INSERT, 31'd9));
		write_register(qpht_pkg::CFG_SLOTS, 7);
		send_request(make_req(qpht_pkg::MODE_SEARCH, 31'd9));
	endtask

	task automatic run_random_phase(input int unsigned size, input int unsigned pct,
			input int unsigned idle_pct);
		write_register(qpht_pkg::CFG_SLOTS, size);
		write_register(qpht_pkg::CFG_LOAD_LIMIT, pct);
		for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
			if ($urandom_range(0, 99) < idle_pct)
				hold_off($urandom_range(1, 24));
			send_request(next_random_request());
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(7, 100, 0);
		run_random_phase(16, 100, 64);
		run_random_phase(31, 90, 21);
		run_random_phase(61, 75, 0);
		run_random_phase(127, 60, 64);
		run_random_phase(TABLE_DEPTH,
			$urandom_range(qpht_pkg::LOAD_MIN, qpht_pkg::LOAD_MAX), 21);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: status %0d slot %0d",
					rsp.status, rsp.slot));
			end else begin
				want = pending_rsp.pop_front();
				asked = pending_req.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("mode %0d key %0d: status %0d, expected %0d",
						asked.mode, asked.key, rsp.status, want.status));
				if (rsp.slot !== want.slot)
					report_mismatch($sformatf("mode %0d key %0d: slot %0d, expected %0d",
						asked.mode, asked.key, rsp.slot, want.slot));
				checked_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_rsp.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			key_mem[i] = '0;
			mark_mem[i] = qpht_pkg::MARK_EMPTY;
		end
		live_count = 0;
		model_slots = qpht_pkg::SLOTS_RESET;
		load_pct = qpht_pkg::LOAD_RESET;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_config();
		test_register_limits();
		test_tombstone_chain();
		test_resize_in_use();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests over %0d register writes; %0d results compared.",
			sent_count, cfg_count, checked_count);
		$display("Table sizes 2 to %0d, load limits 1 to 100, %0d mismatches.",
			TABLE_DEPTH, mismatch_count);
		if (mismatch_count == 0 && pending_rsp.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== quadratic_probe_hash_table.f =====
rtl/qpht_pkg.sv
rtl/qpht_slot_mem.sv
rtl/qpht_mod_unit.sv
rtl/qpht_probe_gen.sv
rtl/quadratic_probe_hash_table.sv
sim/quadratic_probe_hash_table_test.sv
